// ===== rtl/core/base64_strict_line_decoder_top_defines.svh =====
// Assertion macros for the strict base64 line decoder.
// Used at the end of base64_strict_line_decoder_top; expects clk and rst_n in scope.
`ifndef BASE64_STRICT_LINE_DECODER_TOP_DEFINES_SVH
`define BASE64_STRICT_LINE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define B64SLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define B64SLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/b64sld_pkg.sv =====
// Shared types, constants and the alphabet lookup for the strict base64 line decoder.
// No dependencies; used by b64sld_step and base64_strict_line_decoder_top.
package b64sld_pkg;

    localparam int MAX_LINE_GROUPS     = 63;
    localparam int LINE_COUNT_BITS     = 32;
    localparam int GROUPS_BITS         = 6;
    localparam int CHARS_BITS          = 8;
    localparam int LINE_NUMBER_BITS    = 32;

    localparam logic [7:0] NEWLINE    = 8'h0a;
    localparam logic [7:0] PAD_CHAR   = 8'h3d;
    localparam logic [7:0] BAD_SYMBOL = 8'hff;

    localparam logic [GROUPS_BITS-1:0] GROUPS_RESET = GROUPS_BITS'(19);
    localparam logic [CHARS_BITS-1:0]  LINE_CHARS_LIMIT =
        CHARS_BITS'(4 * MAX_LINE_GROUPS);
    localparam logic [LINE_COUNT_BITS-1:0] LINE_COUNT_MAX = '1;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Pad counts
    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;

    // Position inside a four-character group
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // Register indexes
    localparam logic REG_LINE_GROUPS = 1'b0;

    typedef struct packed {
        logic [CHARS_BITS-1:0]      chars_in_line;
        logic [5:0]                 held_bits;
        logic [1:0]                 pad_seen;
        logic [LINE_COUNT_BITS-1:0] line_count;
        logic                       discarding;
    } state_t;

    typedef struct packed {
        logic                        valid;
        logic [1:0]                  kind;
        logic [7:0]                  data;
        logic [LINE_NUMBER_BITS-1:0] line;
    } result_t;

    localparam state_t STATE_RESET = '{
        chars_in_line: '0,
        held_bits:     '0,
        pad_seen:      PAD_NONE,
        line_count:    LINE_COUNT_BITS'(1),
        discarding:    1'b0
    };

    // Standard alphabet; BAD_SYMBOL for anything else
    function automatic logic [7:0] symbol_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h41 && c <= 8'h5a) v = c - 8'h41;
            else if (c >= 8'h61 && c <= 8'h7a) v = c - 8'h61 + 8'd26;
            else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
            else if (c == 8'h2b) v = 8'h3e;
            else if (c == 8'h2f) v = 8'h3f;
            else v = BAD_SYMBOL;
            return v;
        end
    endfunction

endpackage

// ===== rtl/core/base64_strict_line_decoder_top.sv =====
// Top level of the strict base64 line decoder: stream state, result register, APB register.
// Depends on b64sld_pkg, b64sld_step and base64_strict_line_decoder_top_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per transfer with an
//   end_of_input flag on the last byte of a stream. Output channel (out_valid/out_ready)
//   carries at most one result per input byte: a decoded data byte, a done marker, or
//   a format error with the 1-based line number.
//   Results are registered: a result appears on the output the cycle after its byte is
//   taken. Throughput is one byte per cycle while out_ready stays high, set by
//   the single decode stage between the stream state and the result register.
//   in_ready stays high while the result register is empty or being drained, so a
//   stalled receiver holds the current result and blocks new bytes only for as long
//   as out_ready is low. The user must write the line group count over APB at address
//   0 only while the stream is idle; the block does not enforce this. Reset clears the
//   stream state (line 1, no held bits), empties the result register and sets the line
//   group count to 19. After an error, bytes are dropped through the next end-flagged
//   byte, then decoding starts over.
module base64_strict_line_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  out_byte,
    output logic [31:0] line_number,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "base64_strict_line_decoder_top_defines.svh"

    b64sld_pkg::state_t  state_reg;
    b64sld_pkg::state_t  state_next;
    b64sld_pkg::result_t step_res;

    logic [b64sld_pkg::GROUPS_BITS-1:0] groups_reg;
    logic [b64sld_pkg::GROUPS_BITS-1:0] groups_eff;
    logic [b64sld_pkg::CHARS_BITS-1:0]  line_limit;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  result_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [31:0] line_number_reg;

    logic in_fire;
    logic cfg_write;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == b64sld_pkg::REG_LINE_GROUPS);
    assign prdata    = (paddr[2] == b64sld_pkg::REG_LINE_GROUPS) ?
                       {{(32 - b64sld_pkg::GROUPS_BITS){1'b0}}, groups_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            groups_reg <= b64sld_pkg::GROUPS_RESET;
        else if (cfg_write)
            groups_reg <= pwdata[b64sld_pkg::GROUPS_BITS-1:0];
    end

    // Line length in characters; zero groups acts as one
    always_comb
    begin
        groups_eff = groups_reg;
        if (groups_eff == '0)
            groups_eff = b64sld_pkg::GROUPS_BITS'(1);
        if (int'(groups_eff) > b64sld_pkg::MAX_LINE_GROUPS)
            groups_eff = b64sld_pkg::GROUPS_BITS'(b64sld_pkg::MAX_LINE_GROUPS);
    end
    assign line_limit = {groups_eff, 2'b00};

    // Handshake: take a byte whenever the result slot is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    b64sld_step u_step (
        .cur          (state_reg),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .line_limit   (line_limit),
        .nxt          (state_next),
        .res          (step_res)
    );

    // Stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= b64sld_pkg::STATE_RESET;
        else if (in_fire)
            state_reg <= state_next;
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = step_res.valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && step_res.valid)
        begin
            result_kind_reg <= step_res.kind;
            out_byte_reg    <= step_res.data;
            line_number_reg <= step_res.line;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign out_byte    = out_byte_reg;
    assign line_number = line_number_reg;

    // Checks
    `B64SLD_ASSERT_NEXT(a_discard_silent, in_fire && state_reg.discarding, !out_valid_reg,
        "byte dropped while discarding produced a result")
    `B64SLD_ASSERT_NOW(a_chars_bounded, 1'b1,
        state_reg.chars_in_line <= b64sld_pkg::LINE_CHARS_LIMIT,
        "character count ran past the longest line")
    `B64SLD_ASSERT_NOW(a_byte_zero, out_valid_reg && result_kind_reg != b64sld_pkg::KIND_DATA,
        out_byte_reg == 8'h00, "non-data result carries a nonzero byte")
    `B64SLD_ASSERT_NEXT(a_done_restarts,
        in_fire && step_res.valid && step_res.kind == b64sld_pkg::KIND_DONE,
        state_reg.line_count == b64sld_pkg::LINE_COUNT_BITS'(1) &&
        state_reg.chars_in_line == '0 && !state_reg.discarding,
        "stream state not restarted after done")

endmodule

// ===== rtl/core/b64sld_step.sv =====
// Per-byte decode and line checking for the strict base64 line decoder.
// Pure combinational next-state and result logic; depends on b64sld_pkg.
module b64sld_step (
    input  b64sld_pkg::state_t                       cur,
    input  logic [7:0]                               in_byte,
    input  logic                                     end_of_input,
    input  logic [b64sld_pkg::CHARS_BITS-1:0]        line_limit,
    output b64sld_pkg::state_t                       nxt,
    output b64sld_pkg::result_t                      res
);

    logic [1:0] pos;
    logic [7:0] sym;
    logic       fail;
    logic       restart;
    logic [b64sld_pkg::CHARS_BITS-1:0] chars_inc;

    assign pos       = cur.chars_in_line[1:0];
    assign sym       = b64sld_pkg::symbol_value(in_byte);
    assign chars_inc = cur.chars_in_line + b64sld_pkg::CHARS_BITS'(1);

    always_comb
    begin
        nxt       = cur;
        res.valid = 1'b0;
        res.kind  = b64sld_pkg::KIND_DATA;
        res.data  = 8'h00;
        res.line  = b64sld_pkg::LINE_NUMBER_BITS'(cur.line_count);
        fail      = 1'b0;
        restart   = 1'b0;

        if (cur.discarding)
        begin
            // drop bytes until the end-flagged one
            restart = end_of_input;
        end
        else if (in_byte == b64sld_pkg::NEWLINE)
        begin
            if (cur.chars_in_line == '0 || pos != b64sld_pkg::POS_FIRST)
            begin
                fail = 1'b1;
            end
            else if ((cur.pad_seen != b64sld_pkg::PAD_NONE ||
                      cur.chars_in_line < line_limit) && !end_of_input)
            begin
                // short or padded line that is not the last
                fail = 1'b1;
            end
            else if (end_of_input)
            begin
                res.valid = 1'b1;
                res.kind  = b64sld_pkg::KIND_DONE;
                restart   = 1'b1;
            end
            else
            begin
                nxt.chars_in_line = '0;
                nxt.held_bits     = '0;
                if (cur.line_count != b64sld_pkg::LINE_COUNT_MAX)
                    nxt.line_count = cur.line_count + b64sld_pkg::LINE_COUNT_BITS'(1);
            end
        end
        else if (end_of_input || cur.chars_in_line >= line_limit)
        begin
            // missing final newline or overlong line
            fail = 1'b1;
        end
        else if (in_byte == b64sld_pkg::PAD_CHAR)
        begin
            if (pos == b64sld_pkg::POS_THIRD && cur.pad_seen == b64sld_pkg::PAD_NONE)
            begin
                nxt.pad_seen      = b64sld_pkg::PAD_ONE;
                nxt.chars_in_line = chars_inc;
            end
            else if (pos == b64sld_pkg::POS_FOURTH && cur.pad_seen <= b64sld_pkg::PAD_ONE)
            begin
                nxt.pad_seen      = cur.pad_seen + 2'd1;
                nxt.chars_in_line = chars_inc;
            end
            else
            begin
                fail = 1'b1;
            end
        end
        else if (sym == b64sld_pkg::BAD_SYMBOL || cur.pad_seen != b64sld_pkg::PAD_NONE)
        begin
            fail = 1'b1;
        end
        else
        begin
            nxt.chars_in_line = chars_inc;
            res.valid         = 1'b1;
            // splice held bits with the new sextet
            case (pos)
                b64sld_pkg::POS_FIRST:
                begin
                    nxt.held_bits = sym[5:0];
                    res.valid     = 1'b0;
                end
                b64sld_pkg::POS_SECOND:
                begin
                    res.data      = {cur.held_bits, sym[5:4]};
                    nxt.held_bits = {2'b00, sym[3:0]};
                end
                b64sld_pkg::POS_THIRD:
                begin
                    res.data      = {cur.held_bits[3:0], sym[5:2]};
                    nxt.held_bits = {4'b0000, sym[1:0]};
                end
                default:
                begin
                    res.data      = {cur.held_bits[1:0], sym[5:0]};
                    nxt.held_bits = '0;
                end
            endcase
        end

        // error result, then restart or discard to end of stream
        if (fail)
        begin
            res.valid = 1'b1;
            res.kind  = b64sld_pkg::KIND_ERROR;
            res.data  = 8'h00;
            if (end_of_input)
                restart = 1'b1;
            else
                nxt.discarding = 1'b1;
        end

        if (restart)
            nxt = b64sld_pkg::STATE_RESET;
    end

endmodule

// ===== tb/base64_strict_line_decoder_top_test.sv =====
// Self-checking testbench for base64_strict_line_decoder_top: a scoreboard class predicts
// every decode result, and plain tasks and processes drive the byte, result and APB ports.
// Depends on b64sld_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module base64_strict_line_decoder_top_test;

    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned PHASE_ITEMS   = 250;
    localparam int unsigned NUM_PHASES    = 8;
    localparam logic [2:0]  GROUPS_ADDR   = 3'(4 * b64sld_pkg::REG_LINE_GROUPS);

    typedef struct packed {
        logic [1:0]                              kind;
        logic [7:0]                              data;
        logic [b64sld_pkg::LINE_NUMBER_BITS-1:0] line;
    } decoded_result_t;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } text_item_t;

    typedef enum {
        SWAP_BYTE, EARLY_END, DROP_NEWLINE, EXTRA_SYMBOL, DROP_BYTE, EXTRA_PAD,
        TRAILING_EMPTY_LINE
    } damage_t;

    // Predicts decoder output per accepted byte and checks results in order
    class decode_scoreboard;
        logic [5:0]                             groups;
        logic [7:0]                             chars_in_line;
        logic [5:0]                             held_bits;
        logic [1:0]                             pad_seen;
        logic [b64sld_pkg::LINE_COUNT_BITS-1:0] line_count;
        logic                                   discarding;
        decoded_result_t                        expected_results[$];
        int unsigned                            errors;
        int unsigned                            results_seen;

        function new();
            groups       = b64sld_pkg::GROUPS_RESET;
            errors       = 0;
            results_seen = 0;
            restart();
        endfunction

        function void restart();
            chars_in_line = '0;
            held_bits     = '0;
            pad_seen      = b64sld_pkg::PAD_NONE;
            line_count    = b64sld_pkg::LINE_COUNT_BITS'(1);
            discarding    = 1'b0;
        endfunction

        function void set_groups(logic [5:0] value);
            groups = value;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void push(logic [1:0] kind, logic [7:0] data);
            decoded_result_t r;
            r.kind = kind;
            r.data = data;
            r.line = b64sld_pkg::LINE_NUMBER_BITS'(line_count);
            expected_results.push_back(r);
        endfunction

        function void raise_error(logic last);
            push(b64sld_pkg::KIND_ERROR, 8'h00);
            if (last) restart();
            else discarding = 1'b1;
        endfunction

        // Alphabet value, -1 for anything outside it
        function int sextet_of(logic [7:0] c);
            if (c >= "A" && c <= "Z") return int'(c) - int'("A");
            if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
            if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
            if (c == "+") return 62;
            if (c == "/") return 63;
            return -1;
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            int unsigned limit;
            int          sym;
            logic [5:0]  v6;
            logic [1:0]  pos;
            limit = (groups == 0) ? 4 :
                    (groups > b64sld_pkg::MAX_LINE_GROUPS) ?
                    4 * b64sld_pkg::MAX_LINE_GROUPS : 4 * groups;
            pos = chars_in_line[1:0];

            // dropping everything through the end-flagged byte
            if (discarding)
            begin
                if (last) restart();
                return;
            end

            // line end: length rules, done on the final newline
            if (c == b64sld_pkg::NEWLINE)
            begin
                if (chars_in_line == 0 || pos != b64sld_pkg::POS_FIRST)
                begin
                    raise_error(last);
                    return;
                end
                if ((pad_seen != b64sld_pkg::PAD_NONE || chars_in_line < limit) && !last)
                begin
                    raise_error(last);
                    return;
                end
                if (last)
                begin
                    push(b64sld_pkg::KIND_DONE, 8'h00);
                    restart();
                    return;
                end
                chars_in_line = '0;
                held_bits     = '0;
                if (line_count != b64sld_pkg::LINE_COUNT_MAX) line_count++;
                return;
            end

            if (last || chars_in_line >= limit)
            begin
                raise_error(last);
                return;
            end

            // padding only as third/fourth char of a group
            if (c == b64sld_pkg::PAD_CHAR)
            begin
                if (pos == b64sld_pkg::POS_THIRD && pad_seen == b64sld_pkg::PAD_NONE)
                    pad_seen = b64sld_pkg::PAD_ONE;
                else if (pos == b64sld_pkg::POS_FOURTH && pad_seen <= b64sld_pkg::PAD_ONE)
                    pad_seen++;
                else
                begin
                    raise_error(last);
                    return;
                end
                chars_in_line++;
                return;
            end

            sym = sextet_of(c);
            if (sym < 0 || pad_seen != b64sld_pkg::PAD_NONE)
            begin
                raise_error(last);
                return;
            end
            v6 = 6'(sym);
            chars_in_line++;
            case (pos)
                b64sld_pkg::POS_FIRST: held_bits = v6;
                b64sld_pkg::POS_SECOND:
                begin
                    push(b64sld_pkg::KIND_DATA, {held_bits, v6[5:4]});
                    held_bits = {2'b00, v6[3:0]};
                end
                b64sld_pkg::POS_THIRD:
                begin
                    push(b64sld_pkg::KIND_DATA, {held_bits[3:0], v6[5:2]});
                    held_bits = {4'b0000, v6[1:0]};
                end
                default:
                begin
                    push(b64sld_pkg::KIND_DATA, {held_bits[1:0], v6});
                    held_bits = '0;
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data,
                                   logic [b64sld_pkg::LINE_NUMBER_BITS-1:0] line);
            decoded_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: kind %0d byte %02h line %0d",
                         $time, kind, data, line);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind)
            begin
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (data !== want.data)
            begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
            if (line !== want.line)
            begin
                $display("%0t: line_number expected %0d actual %0d", $time, want.line, line);
                errors++;
            end
        endfunction

        function void check_leftover();
            if (expected_results.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived, first kind %0d line %0d",
                         $time, expected_results.size(), expected_results[0].kind,
                         expected_results[0].line);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        end_of_input;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [31:0] line_number;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    decode_scoreboard decode_sb;
    text_item_t       text_q[$];
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      bytes_sent;
    int unsigned      cycles;

    base64_strict_line_decoder_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .out_byte     (out_byte),
        .line_number  (line_number),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Both transfers sampled at the rising edge; inputs noted before results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready) decode_sb.note_byte(in_byte, end_of_input);
            if (out_valid && out_ready) decode_sb.check_result(result_kind, out_byte, line_number);
        end
    end

    // Run limit
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random backpressure, plus two long holds that fill the block
    initial
    begin
        int unsigned next_hold;
        next_hold = 400;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (decode_sb != null && decode_sb.results_seen >= next_hold)
            begin
                next_hold = (next_hold < 1000) ? 1300 : 32'hffff_ffff;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] sextet_char(int unsigned v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    function automatic void push_item(logic [7:0] text, logic last);
        text_item_t it;
        it.text = text;
        it.last = last;
        text_q.push_back(it);
    endfunction

    function automatic void push_text(string s, logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], last_on_end && (i == s.len() - 1));
    endfunction

    // Well-formed stream: some full lines, then a short or full last line, maybe padded
    function automatic void add_good_stream(int unsigned g);
        int unsigned eff;
        int unsigned full_lines;
        int unsigned last_groups;
        int unsigned pads;
        eff = (g == 0) ? 1 : g;
        full_lines = $urandom_range(eff > 16 ? 1 : 3, 0);
        for (int l = 0; l < full_lines; l++)
        begin
            for (int n = 0; n < 4 * eff; n++) push_item(sextet_char($urandom_range(63)), 1'b0);
            push_item(b64sld_pkg::NEWLINE, 1'b0);
        end
        last_groups = $urandom_range(eff, 1);
        pads = $urandom_range(2, 0);
        for (int n = 0; n < 4 * last_groups; n++)
            push_item((n >= 4 * last_groups - pads) ? b64sld_pkg::PAD_CHAR
                                                     : sextet_char($urandom_range(63)), 1'b0);
        push_item(b64sld_pkg::NEWLINE, 1'b1);
    endfunction

    // Break one spot of the stream that was just built
    function automatic void damage_stream();
        int unsigned idx;
        text_item_t  it;
        idx = $urandom_range(text_q.size() - 1);
        it.last = 1'b0;
        case (damage_t'($urandom_range(6)))
            SWAP_BYTE:    text_q[idx].text = 8'($urandom);
            EARLY_END:    text_q[idx].last = 1'b1;
            DROP_NEWLINE: text_q.delete(text_q.size() - 1);
            EXTRA_SYMBOL:
            begin
                it.text = sextet_char($urandom_range(63));
                text_q.insert(idx, it);
            end
            DROP_BYTE:    text_q.delete(idx);
            EXTRA_PAD:
            begin
                it.text = b64sld_pkg::PAD_CHAR;
                text_q.insert(idx, it);
            end
            default:
            begin
                text_q[text_q.size() - 1].last = 1'b0;
                push_item(b64sld_pkg::NEWLINE, 1'b0);
            end
        endcase
        text_q[text_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_noise();
        int unsigned len;
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
            push_item(8'($urandom), (i == len - 1) || ($urandom_range(99) < 5));
    endfunction

    // Idle mix follows how far the run has got
    function automatic void update_idle_mode();
        if (bytes_sent < 690)
        begin
            send_idle_pct = 7;
            recv_idle_pct = 66;
        end
        else if (bytes_sent < 1360)
        begin
            send_idle_pct = 66;
            recv_idle_pct = 7;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] text, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= text;
        end_of_input <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_stream();
        foreach (text_q[i])
        begin
            update_idle_mode();
            send_byte(text_q[i].text, text_q[i].last);
            bytes_sent++;
        end
        text_q.delete();
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Sender waits for every result, then lets the block settle
    task automatic wait_drained();
        while (decode_sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the line group count, then read it back
    task automatic write_groups(input int unsigned value);
        logic [31:0] want;
        want = value & 32'h3f;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GROUPS_ADDR;
        pwdata  <= ($urandom() & ~32'h3f) | want;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        decode_sb.set_groups(want[5:0]);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $display("%0t: prdata expected %0d actual %0d", $time, want, prdata);
            decode_sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int unsigned phase_groups[NUM_PHASES];
        int unsigned phase_start;
        int unsigned pick;
        decode_sb    = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = 8'h00;
        end_of_input = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        bytes_sent   = 0;
        update_idle_mode();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed streams at the reset line length
        push_text("TWFuQQ==", 1'b0);     // data bytes, double pad, done
        push_item(b64sld_pkg::NEWLINE, 1'b1);
        push_item(b64sld_pkg::NEWLINE, 1'b1);        // empty line
        push_text("+/9z", 1'b0);         // short line that is not last
        push_item(b64sld_pkg::NEWLINE, 1'b0);
        push_item(8'h00, 1'b0);          // dropped after the error
        push_item(8'hff, 1'b1);
        push_text("A=", 1'b0);           // pad too early
        push_item(8'h0d, 1'b1);
        push_text("abc", 1'b1);          // end flag on a data char
        push_item(8'hff, 1'b1);          // bad byte on the end flag
        send_stream();
        stop_sending();
        wait_drained();

        // Random phases over several line lengths, extremes included
        phase_groups = '{1, 0, 63, 2, 19, 5, 1, 0};
        phase_groups[NUM_PHASES - 1] = $urandom_range(12, 3);
        foreach (phase_groups[p])
        begin
            write_groups(phase_groups[p]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 90) add_good_stream(phase_groups[p]);
                if (pick >= 70 && pick < 90) damage_stream();
                if (pick >= 90) add_noise();
                send_stream();
            end
            stop_sending();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        decode_sb.check_leftover();
        if (decode_sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
